// ===== design/cpel_pkg.sv =====
// Package for the closest-point-on-edge-list unit.
// Holds the transaction structs, the fixed widths and the sequencer states.
// No dependencies.
package cpel_pkg;

    localparam int COORD_BITS  = 24;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int SUM_BITS    = PROD_BITS + 2;
    localparam int DIST_BITS   = 2 * COORD_BITS + 2;
    localparam int T_FRAC_BITS = 16;
    localparam int MUL_STEPS   = DIFF_BITS;
    localparam int CNT_BITS    = 5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic signed [COORD_BITS-1:0] target_z;
        logic signed [COORD_BITS-1:0] edge_a_x;
        logic signed [COORD_BITS-1:0] edge_a_y;
        logic signed [COORD_BITS-1:0] edge_a_z;
        logic signed [COORD_BITS-1:0] edge_b_x;
        logic signed [COORD_BITS-1:0] edge_b_y;
        logic signed [COORD_BITS-1:0] edge_b_z;
        logic                         last_edge;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] closest_x;
        logic signed [COORD_BITS-1:0] closest_y;
        logic signed [COORD_BITS-1:0] closest_z;
        logic        [DIST_BITS-1:0]  distance_sq;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step;
        logic neg;
    } t_lane_ctl;

    typedef enum logic [3:0] {
        S_IDLE, S_LDM, S_MAG, S_LDD, S_DOT, S_SEL, S_DIV,
        S_ILD, S_INT, S_PNT, S_DLD, S_DST, S_SUM
    } t_state;

endpackage

// ===== design/cpel_mul_lane.sv =====
// Bit-serial signed multiplier lane: one multiplier bit per cycle while i_ctl.step is high.
// Depends on cpel_pkg (widths, lane control struct).
module cpel_mul_lane (
    input  logic                                  i_clk,
    input  cpel_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [cpel_pkg::DIFF_BITS-1:0] i_mcand,
    input  logic signed [cpel_pkg::DIFF_BITS-1:0] i_mplier,
    output logic signed [cpel_pkg::PROD_BITS-1:0] o_acc
);
    import cpel_pkg::*;

    logic signed [PROD_BITS-1:0] r_mc;
    logic signed [PROD_BITS-1:0] r_acc;
    logic        [DIFF_BITS-1:0] r_mp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mc  <= {{(PROD_BITS-DIFF_BITS){i_mcand[DIFF_BITS-1]}}, i_mcand};
            r_mp  <= i_mplier;
            r_acc <= '0;
        end else if (i_ctl.step) begin
            // sign bit of the multiplier carries negative weight
            if (r_mp[0]) begin
                r_acc <= i_ctl.neg ? r_acc - r_mc : r_acc + r_mc;
            end
            r_mc <= r_mc <<< 1;
            r_mp <= r_mp >> 1;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== design/closest_point_on_edge_list_unit.sv =====
// Closest point on a list of 3D segments, bit-serial datapath.
// Depends on cpel_pkg and cpel_mul_lane.
//
// Input channel (i_in, i_in_valid, o_in_stall): one transaction per edge,
// carrying the target, endpoints A and B, and a last-edge mark. A new
// edge is taken only when the sequencer is idle.
// Per edge: three bit-serial multiplier lanes form |B-A|^2 and
// dot(T-A,B-A), a restoring divider gives t one bit a cycle, the lanes
// interpolate the point and square the distance. When t clamps to an
// endpoint, the divide and the interpolation are skipped.
// Output channel (o_out, o_out_valid, i_out_stall): on the last edge the
// kept point and squared distance go into an output register. The next
// edge is accepted while the result waits; only a further last edge
// holds in its final cycle until the output register is free.
// Reset (synchronous, active low) clears the sequencer, drops o_out_valid
// and sets the kept distance to its maximum.
module closest_point_on_edge_list_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpel_pkg::t_in_item  i_in,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output cpel_pkg::t_out_item o_out,
    output logic                o_out_valid,
    input  logic                i_out_stall
);
    import cpel_pkg::*;

    localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(MUL_STEPS - 1);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(T_FRAC_BITS - 1);

    t_state r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt;
    t_in_item r_item;
    logic signed [DIFF_BITS-1:0]  r_ab [3];
    logic signed [DIFF_BITS-1:0]  r_at [3];
    logic signed [COORD_BITS-1:0] r_p [3];
    logic [DIST_BITS-1:0]         r_mag;
    logic signed [SUM_BITS-1:0]   r_dot;
    logic [DIST_BITS-1:0]         r_rem;
    logic [T_FRAC_BITS-1:0]       r_q;
    logic [DIST_BITS-1:0]         r_best_d;
    logic signed [COORD_BITS-1:0] r_best_p [3];
    t_out_item r_out;
    logic r_out_valid;

    logic signed [COORD_BITS-1:0] in_t [3];
    logic signed [COORD_BITS-1:0] in_a [3];
    logic signed [COORD_BITS-1:0] in_b [3];
    logic signed [COORD_BITS-1:0] it_t [3];
    logic signed [COORD_BITS-1:0] it_a [3];
    logic signed [DIFF_BITS-1:0]  c [3];
    logic signed [DIFF_BITS-1:0]  mcand [3];
    logic signed [DIFF_BITS-1:0]  mplier [3];
    logic signed [PROD_BITS-1:0]  acc [3];
    logic signed [PROD_BITS:0]    rnd [3];
    logic signed [PROD_BITS:0]    shr [3];
    logic signed [DIFF_BITS-1:0]  pnew [3];
    logic signed [SUM_BITS-1:0]   lane_sum;
    logic [DIST_BITS:0]           div_sh;
    logic [DIST_BITS:0]           div_diff;
    logic [DIST_BITS-1:0]         dist_sq;
    logic upd, out_free, go;
    t_lane_ctl lane_ctl;

    assign in_t = '{i_in.target_x, i_in.target_y, i_in.target_z};
    assign in_a = '{i_in.edge_a_x, i_in.edge_a_y, i_in.edge_a_z};
    assign in_b = '{i_in.edge_b_x, i_in.edge_b_y, i_in.edge_b_z};
    assign it_t = '{r_item.target_x, r_item.target_y, r_item.target_z};
    assign it_a = '{r_item.edge_a_x, r_item.edge_a_y, r_item.edge_a_z};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c[k]    = {it_t[k][COORD_BITS-1], it_t[k]} - {r_p[k][COORD_BITS-1], r_p[k]};
            rnd[k]  = {acc[k][PROD_BITS-1], acc[k]}
                      + ((PROD_BITS+1)'(1) << (T_FRAC_BITS - 1));
            shr[k]  = rnd[k] >>> T_FRAC_BITS;
            pnew[k] = {it_a[k][COORD_BITS-1], it_a[k]} + shr[k][DIFF_BITS-1:0];
        end
        lane_sum = {{2{acc[0][PROD_BITS-1]}}, acc[0]}
                 + {{2{acc[1][PROD_BITS-1]}}, acc[1]}
                 + {{2{acc[2][PROD_BITS-1]}}, acc[2]};
        dist_sq  = (lane_sum[SUM_BITS-1:DIST_BITS] != '0) ? '1 : lane_sum[DIST_BITS-1:0];
        upd      = dist_sq < r_best_d;
        div_sh   = {r_rem, 1'b0};
        div_diff = div_sh - {1'b0, r_mag};
        out_free = !r_out_valid || !i_out_stall;
        go       = !r_item.last_edge || out_free;
    end

    // lane operand select
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (r_state)
                S_LDD: begin
                    mcand[k]  = r_ab[k];
                    mplier[k] = r_at[k];
                end
                S_ILD: begin
                    mcand[k]  = r_ab[k];
                    mplier[k] = {{(DIFF_BITS-T_FRAC_BITS){1'b0}}, r_q};
                end
                S_DLD: begin
                    mcand[k]  = c[k];
                    mplier[k] = c[k];
                end
                default: begin
                    mcand[k]  = r_ab[k];
                    mplier[k] = r_ab[k];
                end
            endcase
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        cpel_mul_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_mcand  (mcand[g]),
            .i_mplier (mplier[g]),
            .o_acc    (acc[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_LDM;
            S_LDM:  n_state = S_MAG;
            S_MAG:  if (r_cnt == MUL_LAST) n_state = S_LDD;
            S_LDD:  n_state = S_DOT;
            S_DOT:  if (r_cnt == MUL_LAST) n_state = S_SEL;
            S_SEL: begin
                if (lane_sum <= 0 || lane_sum >= $signed({2'b0, r_mag})) n_state = S_DLD;
                else n_state = S_DIV;
            end
            S_DIV:  if (r_cnt == DIV_LAST) n_state = S_ILD;
            S_ILD:  n_state = S_INT;
            S_INT:  if (r_cnt == MUL_LAST) n_state = S_PNT;
            S_PNT:  n_state = S_DLD;
            S_DLD:  n_state = S_DST;
            S_DST:  if (r_cnt == MUL_LAST) n_state = S_SUM;
            S_SUM:  if (go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        lane_ctl.load = (r_state == S_LDM) || (r_state == S_LDD)
                     || (r_state == S_ILD) || (r_state == S_DLD);
        lane_ctl.step = (r_state == S_MAG) || (r_state == S_DOT)
                     || (r_state == S_INT) || (r_state == S_DST);
        lane_ctl.neg  = lane_ctl.step && (r_cnt == MUL_LAST);
        o_in_stall    = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_best_d    <= '1;
            r_best_p    <= '{'0, '0, '0};
        end else begin
            r_state <= n_state;
            if (lane_ctl.step || r_state == S_DIV) r_cnt <= r_cnt + 1'b1;
            else r_cnt <= '0;
            if (!i_out_stall) r_out_valid <= 1'b0;
            if (r_state == S_SUM && go) begin
                if (r_item.last_edge) begin
                    r_out_valid       <= 1'b1;
                    r_out.closest_x   <= upd ? r_p[0] : r_best_p[0];
                    r_out.closest_y   <= upd ? r_p[1] : r_best_p[1];
                    r_out.closest_z   <= upd ? r_p[2] : r_best_p[2];
                    r_out.distance_sq <= upd ? dist_sq : r_best_d;
                    r_best_d          <= '1;
                    r_best_p          <= '{'0, '0, '0};
                end else if (upd) begin
                    r_best_d <= dist_sq;
                    r_best_p <= r_p;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_in;
                for (int k = 0; k < 3; k++) begin
                    r_ab[k] <= {in_b[k][COORD_BITS-1], in_b[k]}
                             - {in_a[k][COORD_BITS-1], in_a[k]};
                    r_at[k] <= {in_t[k][COORD_BITS-1], in_t[k]}
                             - {in_a[k][COORD_BITS-1], in_a[k]};
                end
            end
            S_LDD: r_mag <= lane_sum[DIST_BITS-1:0];
            S_SEL: begin
                // dot is taken from the lanes on the selection cycle
                r_dot <= lane_sum;
                r_rem <= lane_sum[DIST_BITS-1:0];
                r_q   <= '0;
                if (lane_sum <= 0) r_p <= it_a;
                else if (lane_sum >= $signed({2'b0, r_mag}))
                    r_p <= '{r_item.edge_b_x, r_item.edge_b_y, r_item.edge_b_z};
            end
            S_DIV: begin
                if (div_sh >= {1'b0, r_mag}) begin
                    r_rem <= div_diff[DIST_BITS-1:0];
                    r_q   <= {r_q[T_FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= div_sh[DIST_BITS-1:0];
                    r_q   <= {r_q[T_FRAC_BITS-2:0], 1'b0};
                end
            end
            S_PNT: begin
                for (int k = 0; k < 3; k++) r_p[k] <= pnew[k][COORD_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dot > 0) && (r_dot < $signed({2'b0, r_mag})))
        else $error("divide entered with t outside (0,1)");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ILD) |-> (r_rem < r_mag))
        else $error("divider remainder not below divisor");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && r_item.last_edge && !r_out_valid) |=> r_out_valid)
        else $error("last edge finished without a result");
`endif

endmodule

// ===== bench/closest_point_on_edge_list_unit_tb.sv =====
// Testbench for closest_point_on_edge_list_unit: directed and random edge sets,
// predicted by a fixed-point closest-point model and checked at the output.
// Depends on cpel_pkg and the unit under test.
module closest_point_on_edge_list_unit_tb;
    import cpel_pkg::*;

    localparam longint DIST_MAX   = (64'd1 << DIST_BITS) - 1;
    localparam int     CYCLE_CAP  = 2000000;
    localparam int     PAUSE_AT   = 700;
    localparam int     QUIET_LO   = 5000;
    localparam int     QUIET_HI   = 40000;
    localparam int     RANDOM_ITEMS = 1800;

    logic      i_clk;
    logic      i_rst_n;
    t_in_item  in_bus;
    logic      in_valid;
    logic      o_in_stall;
    t_out_item o_out;
    logic      o_out_valid;
    logic      out_stall;

    closest_point_on_edge_list_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .o_out      (o_out),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall)
    );

    t_in_item  edge_q[$];
    t_out_item nearest_q[$];
    int        errors;
    int        cycles;
    int        edges_sent;
    logic      took;

    // running minimum over the current edge set
    logic [DIST_BITS-1:0] kept_dist;
    longint               kept_x, kept_y, kept_z;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit quiet();
        return cycles >= QUIET_LO && cycles < QUIET_HI;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    function automatic void clear_set();
        kept_dist = '1;
        kept_x = 0;
        kept_y = 0;
        kept_z = 0;
    endfunction

    function automatic void track_edge(input t_in_item it);
        longint tp[3], ap[3], bp[3], ab[3], pt[3];
        longint mag, dot, c, dist_sq;
        longint rem, quo;
        t_out_item res;
        tp[0] = longint'(it.target_x); tp[1] = longint'(it.target_y);
        tp[2] = longint'(it.target_z);
        ap[0] = longint'(it.edge_a_x); ap[1] = longint'(it.edge_a_y);
        ap[2] = longint'(it.edge_a_z);
        bp[0] = longint'(it.edge_b_x); bp[1] = longint'(it.edge_b_y);
        bp[2] = longint'(it.edge_b_z);
        mag = 0;
        dot = 0;
        for (int k = 0; k < 3; k++) begin
            ab[k] = bp[k] - ap[k];
            mag += ab[k] * ab[k];
            dot += (tp[k] - ap[k]) * ab[k];
        end
        if (dot <= 0) begin
            for (int k = 0; k < 3; k++) pt[k] = ap[k];
        end else if (dot >= mag) begin
            for (int k = 0; k < 3; k++) pt[k] = bp[k];
        end else begin
            rem = dot;
            quo = 0;
            for (int i = 0; i < T_FRAC_BITS; i++) begin
                rem = rem <<< 1;
                quo = quo <<< 1;
                if (rem >= mag) begin
                    rem -= mag;
                    quo |= 1;
                end
            end
            // round to nearest, ties up; arithmetic shift is a floor
            for (int k = 0; k < 3; k++)
                pt[k] = ap[k] + ((ab[k] * quo + (64'sd1 <<< (T_FRAC_BITS - 1)))
                                 >>> T_FRAC_BITS);
        end
        dist_sq = 0;
        for (int k = 0; k < 3; k++) begin
            c = tp[k] - pt[k];
            dist_sq += c * c;
        end
        if (dist_sq > DIST_MAX) dist_sq = DIST_MAX;
        if (dist_sq < longint'({14'd0, kept_dist})) begin
            kept_dist = dist_sq[DIST_BITS-1:0];
            kept_x = pt[0];
            kept_y = pt[1];
            kept_z = pt[2];
        end
        if (it.last_edge) begin
            res.closest_x   = kept_x[COORD_BITS-1:0];
            res.closest_y   = kept_y[COORD_BITS-1:0];
            res.closest_z   = kept_z[COORD_BITS-1:0];
            res.distance_sq = kept_dist;
            nearest_q.push_back(res);
            clear_set();
        end
    endfunction

    function automatic logic [COORD_BITS-1:0] rnd_coord(input int spread);
        case (spread)
            0: return COORD_BITS'($urandom);
            1: return COORD_BITS'($signed($urandom_range(0, 2047)) - 1024);
            default: return COORD_BITS'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic t_in_item mk(input logic [COORD_BITS-1:0] tx, ty, tz, ax, ay, az,
                                    bx, by, bz, input logic last);
        t_in_item it;
        it.target_x = tx; it.target_y = ty; it.target_z = tz;
        it.edge_a_x = ax; it.edge_a_y = ay; it.edge_a_z = az;
        it.edge_b_x = bx; it.edge_b_y = by; it.edge_b_z = bz;
        it.last_edge = last;
        return it;
    endfunction

    // stimulus
    initial begin
        logic [COORD_BITS-1:0] mx, mn, tx, ty, tz;
        int n, spread, made;
        t_in_item it;
        mx = 24'h7fffff;
        mn = 24'h800000;
        // extremes, single-edge sets
        edge_q.push_back(mk(mx, mx, mx, mn, mn, mn, mx, mx, mx, 1'b1));
        edge_q.push_back(mk(mn, mn, mn, mx, mx, mx, mn, mn, mn, 1'b1));
        edge_q.push_back(mk(mx, mn, mx, mn, mn, mn, mn, mn, mn, 1'b1));
        edge_q.push_back(mk(mn, mx, mn, mx, mn, mx, mn, mx, mn, 1'b1));
        // zero-length edge
        edge_q.push_back(mk(24'd100, 24'd5, -24'd7, 24'd3, 24'd3, 24'd3,
                            24'd3, 24'd3, 24'd3, 1'b1));
        // clamp to A, clamp to B, interior point, within one set
        edge_q.push_back(mk(-24'd50, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
                            24'd100, 24'd0, 24'd0, 1'b0));
        edge_q.push_back(mk(-24'd50, 24'd0, 24'd0, 24'd200, 24'd10, 24'd0,
                            24'd100, 24'd10, 24'd0, 1'b0));
        edge_q.push_back(mk(-24'd50, 24'd0, 24'd0, -24'd100, 24'd30, 24'd0,
                            24'd0, 24'd33, 24'd7, 1'b1));
        // equal distances: earlier edge kept
        edge_q.push_back(mk(24'd0, 24'd0, 24'd0, 24'd10, 24'd0, 24'd0,
                            24'd20, 24'd0, 24'd0, 1'b0));
        edge_q.push_back(mk(24'd0, 24'd0, 24'd0, -24'd10, 24'd0, 24'd0,
                            -24'd20, 24'd0, 24'd0, 1'b0));
        edge_q.push_back(mk(24'd0, 24'd0, 24'd0, 24'd0, 24'd10, 24'd0,
                            24'd0, 24'd20, 24'd0, 1'b1));
        // target differing between edges
        edge_q.push_back(mk(24'd1000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
                            24'd0, 24'd0, 24'd0, 1'b0));
        edge_q.push_back(mk(-24'd1000, 24'd77, 24'd3, 24'd0, 24'd0, 24'd0,
                            24'd0, 24'd0, 24'd0, 1'b1));
        // interior with rounding on odd deltas
        edge_q.push_back(mk(24'd7, 24'd3, -24'd1, -24'd3, 24'd1, 24'd0,
                            24'd13, -24'd5, 24'd9, 1'b1));
        edge_q.push_back(mk(mx, mx, mx, mn, mn, mn, mn, mx, mx, 1'b1));

        made = 0;
        while (made < RANDOM_ITEMS) begin
            n = $urandom_range(1, 6);
            spread = $urandom_range(0, 2);
            tx = rnd_coord(spread); ty = rnd_coord(spread); tz = rnd_coord(spread);
            for (int e = 0; e < n; e++) begin
                it = mk(tx, ty, tz, rnd_coord(spread), rnd_coord(spread), rnd_coord(spread),
                        rnd_coord(spread), rnd_coord(spread), rnd_coord(spread),
                        e == n - 1);
                if ($urandom_range(0, 9) == 0) begin
                    it.target_x = rnd_coord(spread);
                    it.target_z = rnd_coord(spread);
                end
                if ($urandom_range(0, 19) == 0) begin
                    it.edge_b_x = it.edge_a_x;
                    it.edge_b_y = it.edge_a_y;
                    it.edge_b_z = it.edge_a_z;
                end
                edge_q.push_back(it);
            end
            made += n;
        end

        wait (i_rst_n === 1'b1);
        wait (edge_q.size() == 0 && in_valid == 1'b0 && nearest_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("PASS closest_point_on_edge_list_unit");
        else
            $display("FAIL closest_point_on_edge_list_unit");
        $finish;
    end

    // reset, cycle count and timeout
    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout at cycle %0d", cycles);
            $display("FAIL closest_point_on_edge_list_unit");
            $finish;
        end
    end

    // driver: holds the payload until the transaction is taken
    always @(negedge i_clk) begin
        out_stall <= !quiet() && ($urandom_range(0, 99) < 24);
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || took) begin
            if (edge_q.size() > 0 && !(edges_sent == PAUSE_AT && nearest_q.size() > 0)
                && (quiet() || $urandom_range(0, 99) >= 24)) begin
                in_bus   <= edge_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on each accepted edge, checks each accepted result
    always @(posedge i_clk) begin
        t_out_item want;
        took <= in_valid && !o_in_stall && i_rst_n;
        if (i_rst_n && in_valid && !o_in_stall) begin
            track_edge(in_bus);
            edges_sent <= edges_sent + 1;
        end
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (nearest_q.size() == 0) begin
                report("unexpected transaction", 0, 0);
            end else begin
                want = nearest_q.pop_front();
                if (o_out.closest_x !== want.closest_x)
                    report("closest_x", o_out.closest_x, want.closest_x);
                if (o_out.closest_y !== want.closest_y)
                    report("closest_y", o_out.closest_y, want.closest_y);
                if (o_out.closest_z !== want.closest_z)
                    report("closest_z", o_out.closest_z, want.closest_z);
                if (o_out.distance_sq !== want.distance_sq)
                    report("distance_sq", o_out.distance_sq, want.distance_sq);
            end
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        edges_sent = 0;
        took = 1'b0;
        in_valid = 1'b0;
        in_bus = '0;
        out_stall = 1'b0;
        clear_set();
    end
endmodule
